>>> hdl/dbba_pkg.sv
// ----------------------------------------------------------------------------
// Disk block bitmap allocator package
// Command codes, status codes, register indexes and fixed field widths that
// are shared by the allocator modules.
// ----------------------------------------------------------------------------
package dbba_pkg;

    localparam int BLOCK_W = 12;
    localparam int COUNT_W = 13;
    localparam int CFG_W   = 13;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_MARK  = 2'd1,
        CMD_ALLOC = 2'd2,
        CMD_COUNT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_RSVD  = 2'd3
    } status_t;

    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_DIR   = 1'b1;

    localparam logic [CFG_W-1:0] TOTAL_RESET = 13'd243;
    localparam logic [CFG_W-1:0] DIR_RESET   = 13'd2;

endpackage

>>> hdl/dbba_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dbba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/dbba_word_unit.sv
// ----------------------------------------------------------------------------
// Map word unit
// Finds the lowest clear bit of a map word, counts its set bits and forms the
// word with one chosen bit set.
// ----------------------------------------------------------------------------
module dbba_word_unit #(
    parameter int WORD_BITS = 16,
    parameter int PW        = $clog2(WORD_BITS),
    parameter int CW        = $clog2(WORD_BITS + 1)
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [PW-1:0]        set_pos,
    output logic                 has_zero,
    output logic [PW-1:0]        zero_pos,
    output logic [CW-1:0]        ones,
    output logic [WORD_BITS-1:0] set_word
);

    always_comb
    begin
        has_zero = 1'b0;
        zero_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (!word[j])
            begin
                has_zero = 1'b1;
                zero_pos = PW'(j);
            end
        end
    end

    always_comb
    begin
        ones = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            ones = ones + CW'(word[j]);
        end
    end

    assign set_word = word | (WORD_BITS'(1) << set_pos);

endmodule

>>> hdl/disk_block_bitmap_allocator_core.sv
// One transaction is processed at a time; the map RAM is walked one word per cycle,
// so its single read port and the shared word unit set the throughput.
// Reset is asynchronous; afterwards a clearing pass over the MAP_WORDS map words (256
// with the default parameters) zeroes the map while in_ready stays low.
// ----------------------------------------------------------------------------
// Disk block bitmap allocator core
// First-fit block allocation map with clear, mark, allocate and count
// commands, an APB configuration port and valid/ready transaction channels.
// ----------------------------------------------------------------------------
module disk_block_bitmap_allocator_core #(
    parameter int WORD_BITS  = 16,
    parameter int MAX_BLOCKS = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dbba_pkg::PADDR_W-1:0]    paddr,
    input  logic [dbba_pkg::PDATA_W-1:0]    pwdata,
    output logic [dbba_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      command,
    input  logic [dbba_pkg::BLOCK_W-1:0]    block_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dbba_pkg::BLOCK_W-1:0]    block_out,
    output logic [dbba_pkg::COUNT_W-1:0]    used_count,
    output logic [1:0]                      status
);

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IW        = AW + 1;
    localparam int PW        = $clog2(WORD_BITS);
    localparam int CW        = $clog2(WORD_BITS + 1);
    localparam int BW_RAW    = $clog2(MAP_WORDS * WORD_BITS + 1);
    localparam int BW        = (BW_RAW > dbba_pkg::CFG_W) ? BW_RAW : dbba_pkg::CFG_W;
    localparam int KW        = dbba_pkg::COUNT_W + 1;

    typedef enum logic [8:0] {
        ST_INIT    = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_CLEAR   = 9'b000000100,
        ST_SEEK    = 9'b000001000,
        ST_MARK_WR = 9'b000010000,
        ST_ALLOC   = 9'b000100000,
        ST_COUNT   = 9'b001000000,
        ST_DONE    = 9'b010000000,
        ST_SPARE   = 9'b100000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [dbba_pkg::CFG_W-1:0]      total_reg;
    logic [dbba_pkg::CFG_W-1:0]      dir_reg;
    logic [IW-1:0]                   rd_idx_reg, rd_idx_next;
    logic [IW-1:0]                   ex_idx_reg, ex_idx_next;
    logic                            pend_reg, pend_next;
    logic [BW-1:0]                   base_reg, base_next;
    logic [dbba_pkg::BLOCK_W-1:0]    rem_reg, rem_next;
    logic [dbba_pkg::COUNT_W-1:0]    acc_reg, acc_next;
    logic [dbba_pkg::BLOCK_W-1:0]    res_block_reg, res_block_next;
    logic [1:0]                      res_status_reg, res_status_next;
    logic                            out_valid_reg, out_valid_next;
    logic [dbba_pkg::BLOCK_W-1:0]    block_out_reg;
    logic [dbba_pkg::COUNT_W-1:0]    used_count_reg;
    logic [1:0]                      status_reg;

    logic                            cfg_write;
    logic                            accept;
    logic                            out_load;
    logic [BW-1:0]                   limit;
    logic [WORD_BITS-1:0]            dir_mask;
    logic                            issue;
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [WORD_BITS-1:0]            ram_wdata;
    logic [WORD_BITS-1:0]            ram_rdata;
    logic [PW-1:0]                   set_pos;
    logic                            has_zero;
    logic [PW-1:0]                   zero_pos;
    logic [CW-1:0]                   ones;
    logic [WORD_BITS-1:0]            set_word;
    logic [BW-1:0]                   found_block;
    logic [KW-1:0]                   acc_sum;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= dbba_pkg::TOTAL_RESET;
            dir_reg   <= dbba_pkg::DIR_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                dbba_pkg::REG_TOTAL: total_reg <= pwdata[dbba_pkg::CFG_W-1:0];
                dbba_pkg::REG_DIR:   dir_reg   <= pwdata[dbba_pkg::CFG_W-1:0];
                default:             total_reg <= total_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            dbba_pkg::REG_TOTAL:
                prdata = {{(dbba_pkg::PDATA_W - dbba_pkg::CFG_W){1'b0}}, total_reg};
            dbba_pkg::REG_DIR:
                prdata = {{(dbba_pkg::PDATA_W - dbba_pkg::CFG_W){1'b0}}, dir_reg};
            default:
                prdata = '0;
        endcase
    end

    assign limit = (BW'(total_reg) > BW'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : BW'(total_reg);

    assign dir_mask = (dir_reg >= dbba_pkg::CFG_W'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                    : ((WORD_BITS'(1) << dir_reg[PW-1:0]) - WORD_BITS'(1));

    dbba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign set_pos = (state_reg == ST_MARK_WR) ? rem_reg[PW-1:0] : zero_pos;

    dbba_word_unit #(
        .WORD_BITS (WORD_BITS),
        .PW        (PW),
        .CW        (CW)
    ) u_word_unit (
        .word     (ram_rdata),
        .set_pos  (set_pos),
        .has_zero (has_zero),
        .zero_pos (zero_pos),
        .ones     (ones),
        .set_word (set_word)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign issue       = (rd_idx_reg < IW'(MAP_WORDS));
    assign found_block = base_reg + BW'(zero_pos);
    assign acc_sum     = KW'(acc_reg) + KW'(ones);

    always_comb
    begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        ex_idx_next     = ex_idx_reg;
        pend_next       = 1'b0;
        base_next       = base_reg;
        rem_next        = rem_reg;
        acc_next        = acc_reg;
        res_block_next  = res_block_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = rd_idx_reg[AW-1:0];
        ram_wdata       = '0;

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                ram_we = 1'b1;
                if ((state_reg == ST_CLEAR) && (rd_idx_reg == '0))
                begin
                    ram_wdata = dir_mask;
                end
                rd_idx_next = rd_idx_reg + IW'(1);
                if (rd_idx_reg == IW'(MAP_WORDS - 1))
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_idx_next     = '0;
                    ex_idx_next     = '0;
                    base_next       = '0;
                    acc_next        = '0;
                    rem_next        = block_in;
                    res_block_next  = '0;
                    res_status_next = dbba_pkg::STAT_OK;
                    case (command)
                        dbba_pkg::CMD_CLEAR:
                            state_next = ST_CLEAR;
                        dbba_pkg::CMD_MARK:
                        begin
                            if (BW'(block_in) >= limit)
                            begin
                                res_status_next = dbba_pkg::STAT_RANGE;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SEEK;
                            end
                        end
                        dbba_pkg::CMD_ALLOC:
                            state_next = ST_ALLOC;
                        dbba_pkg::CMD_COUNT:
                            state_next = ST_COUNT;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEEK:
            begin
                if (rem_reg < dbba_pkg::BLOCK_W'(WORD_BITS))
                begin
                    state_next = ST_MARK_WR;
                end
                else
                begin
                    rem_next    = rem_reg - dbba_pkg::BLOCK_W'(WORD_BITS);
                    rd_idx_next = rd_idx_reg + IW'(1);
                end
            end
            ST_MARK_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = set_word;
                state_next = ST_DONE;
            end
            ST_ALLOC:
            begin
                pend_next = issue;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + IW'(1);
                end
                if (pend_reg)
                begin
                    if (has_zero)
                    begin
                        if (found_block < limit)
                        begin
                            ram_we         = 1'b1;
                            ram_waddr      = ex_idx_reg[AW-1:0];
                            ram_wdata      = set_word;
                            res_block_next = found_block[dbba_pkg::BLOCK_W-1:0];
                        end
                        else
                        begin
                            res_status_next = dbba_pkg::STAT_FULL;
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        base_next   = base_reg + BW'(WORD_BITS);
                        ex_idx_next = ex_idx_reg + IW'(1);
                    end
                end
                else if (!issue)
                begin
                    res_status_next = dbba_pkg::STAT_FULL;
                    state_next      = ST_DONE;
                end
            end
            ST_COUNT:
            begin
                pend_next = issue;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + IW'(1);
                end
                if (pend_reg)
                begin
                    acc_next = (acc_sum > KW'(dbba_pkg::COUNT_MAX)) ? dbba_pkg::COUNT_MAX
                             : acc_sum[dbba_pkg::COUNT_W-1:0];
                end
                else if (!issue)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ex_idx_reg     <= ex_idx_next;
        base_reg       <= base_next;
        rem_reg        <= rem_next;
        acc_reg        <= acc_next;
        res_block_reg  <= res_block_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            block_out_reg  <= res_block_reg;
            used_count_reg <= acc_reg;
            status_reg     <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign block_out  = block_out_reg;
    assign used_count = used_count_reg;
    assign status     = status_reg;

`ifndef NO_ASSERTIONS
    a_full_has_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == dbba_pkg::STAT_FULL)) |-> (block_out == '0))
        else $error("Disk full result carries a block number.");

    a_count_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (used_count != '0)) |-> (status == dbba_pkg::STAT_OK))
        else $error("Non-zero used count with an error status.");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("Map written while the sequencer is idle.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("Input accepted again in the cycle after a transaction.");
`endif

endmodule
